/* rtl/rsoc_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the
// reading statistics block. No dependencies.
package rsoc_pkg;

    localparam int CAPACITY = 256;
    localparam int DATA_W   = 16;
    localparam int TOL_W    = 10;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W    = DATA_W + ADDR_W;
    localparam int ITER_W   = $clog2(SUM_W);
    localparam int SCALE_W  = 10;
    localparam int PROD_W   = DATA_W + TOL_W;
    localparam int OCNT_W   = 9;
    localparam int STAT_W   = 2;

    localparam logic [SCALE_W-1:0] SCALE       = SCALE_W'(1000);
    localparam logic [TOL_W-1:0]   TOL_RESET   = TOL_W'(100);

    localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_OVERFLOW = 2'd2;

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic mul_en;
        logic scan_issue;
        logic out_load;
    } rsoc_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic div_last;
        logic scan_last;
    } rsoc_sts_t;

endpackage

/* rtl/reading_statistics_with_outlier_count_core.sv */
// Top level of the reading statistics block: controller plus datapath.
// Depends on rsoc_pkg, rsoc_ctrl and rsoc_datapath.
//
// Usage: readings arrive on the input channel (in_valid/in_ready), one
// transfer per cycle while a run is loading; last_reading closes the run.
// Up to 256 readings are stored; further ones are dropped and flagged in
// status. The run result appears on the output channel (out_valid/
// out_ready) as one transfer.
// After the closing transfer the block sets up the divider, runs the serial
// divider (one quotient bit per cycle), forms the band bounds, scans the
// stored readings through the memory read port, drains the last compare
// and loads the result register; an empty run goes straight from setup to
// the result. in_ready is low in that time.
// The result sits in an output register: the next run loads while it waits.
// If the receiver stalls, a finished run waits before its result register
// load until the previous result has been taken.
// Reset clears the run statistics, drops any pending result and sets the
// tolerance to 10.0 percent. cfg_write_en writes the tolerance at once.
module reading_statistics_with_outlier_count_core
    import rsoc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  logic [TOL_W-1:0]    cfg_write_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [DATA_W-1:0]   reading,
    input  logic                last_reading,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [DATA_W-1:0]   minimum_value,
    output logic [DATA_W-1:0]   maximum_value,
    output logic [DATA_W-1:0]   spread,
    output logic [DATA_W-1:0]   mean_value,
    output logic [OCNT_W-1:0]   outside_count,
    output logic [OCNT_W-1:0]   reading_count,
    output logic [STAT_W-1:0]   status
);

    rsoc_cmd_t cmd;
    rsoc_sts_t sts;

    rsoc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .last_reading (last_reading),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    rsoc_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .reading        (reading),
        .minimum_value  (minimum_value),
        .maximum_value  (maximum_value),
        .spread         (spread),
        .mean_value     (mean_value),
        .outside_count  (outside_count),
        .reading_count  (reading_count),
        .status         (status)
    );

endmodule

/* rtl/rsoc_datapath.sv */
// Datapath: sample memory, running min/max/sum, serial divider for the mean,
// band bounds, outlier scan and the result register. Depends on rsoc_pkg.
module rsoc_datapath
    import rsoc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  rsoc_cmd_t           cmd,
    output rsoc_sts_t           sts,
    input  logic                cfg_write_en,
    input  logic [TOL_W-1:0]    cfg_write_data,
    input  logic [DATA_W-1:0]   reading,
    output logic [DATA_W-1:0]   minimum_value,
    output logic [DATA_W-1:0]   maximum_value,
    output logic [DATA_W-1:0]   spread,
    output logic [DATA_W-1:0]   mean_value,
    output logic [OCNT_W-1:0]   outside_count,
    output logic [OCNT_W-1:0]   reading_count,
    output logic [STAT_W-1:0]   status
);

    logic [DATA_W-1:0] mem [CAPACITY];

    logic [TOL_W-1:0]  tol_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [DATA_W-1:0] min_reg;
    logic [DATA_W-1:0] max_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic              ovf_reg;

    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [ITER_W-1:0] iter_reg;
    logic [CNT_W:0]    trial;
    logic              trial_ge;

    logic [PROD_W-1:0] center_reg;
    logic [PROD_W-1:0] half_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic              rd_vld_reg;
    logic [CNT_W-1:0]  outside_reg;

    logic              has_room;
    logic [CNT_W-1:0]  count_m1;
    logic [DATA_W-1:0] mean;
    logic [PROD_W-1:0] scaled;
    logic [PROD_W:0]   upper;
    logic              above, below;

    assign has_room = count_reg < CNT_W'(CAPACITY);
    assign count_m1 = count_reg - CNT_W'(1);
    assign mean     = quo_reg[DATA_W-1:0];

    assign sts.count_zero = (count_reg == '0);
    assign sts.div_last   = (iter_reg == ITER_W'(SUM_W - 1));
    assign sts.scan_last  = (CNT_W'(idx_reg) == count_m1);

    // tolerance register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            tol_reg <= TOL_RESET;
        end
        else if (cfg_write_en) begin
            tol_reg <= cfg_write_data;
        end
    end

    // run statistics; clear once the result has been taken into the output register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            count_reg <= '0;
            min_reg   <= '1;
            max_reg   <= '0;
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.out_load) begin
            count_reg <= '0;
            min_reg   <= '1;
            max_reg   <= '0;
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.load) begin
            if (has_room) begin
                count_reg <= count_reg + CNT_W'(1);
                if (reading < min_reg) begin
                    min_reg <= reading;
                end
                if (reading > max_reg) begin
                    max_reg <= reading;
                end
                sum_reg <= sum_reg + SUM_W'(reading);
            end
            else begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // sample memory: one write port, one registered read port
    always_ff @(posedge clk) begin
        if (cmd.load && has_room) begin
            mem[count_reg[ADDR_W-1:0]] <= reading;
        end
        if (cmd.scan_issue) begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    // restoring divider, one quotient bit per cycle
    always_comb begin
        trial    = {rem_reg, quo_reg[SUM_W-1]};
        trial_ge = trial >= {1'b0, count_reg};
        rem_next = trial_ge ? CNT_W'(trial - {1'b0, count_reg}) : trial[CNT_W-1:0];
        quo_next = {quo_reg[SUM_W-2:0], trial_ge};
    end

    always_ff @(posedge clk) begin
        if (cmd.div_init) begin
            rem_reg <= '0;
            quo_reg <= sum_reg;
        end
        else if (cmd.div_step) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            iter_reg <= '0;
        end
        else if (cmd.div_init) begin
            iter_reg <= '0;
        end
        else if (cmd.div_step) begin
            iter_reg <= iter_reg + ITER_W'(1);
        end
    end

    // band center and half-width
    always_ff @(posedge clk) begin
        if (cmd.mul_en) begin
            center_reg <= PROD_W'(mean) * PROD_W'(SCALE);
            half_reg   <= PROD_W'(mean) * PROD_W'(tol_reg);
        end
    end

    // outlier scan over the stored readings
    assign scaled = PROD_W'(rd_data_reg) * PROD_W'(SCALE);
    assign upper  = {1'b0, center_reg} + {1'b0, half_reg};
    assign above  = {1'b0, scaled} > upper;
    assign below  = ({1'b0, scaled} + {1'b0, half_reg}) < {1'b0, center_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            idx_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            outside_reg <= '0;
        end
        else begin
            rd_vld_reg <= cmd.scan_issue;
            if (cmd.mul_en) begin
                idx_reg     <= '0;
                outside_reg <= '0;
            end
            else begin
                if (cmd.scan_issue) begin
                    idx_reg <= idx_reg + ADDR_W'(1);
                end
                if (rd_vld_reg && (above || below)) begin
                    outside_reg <= outside_reg + CNT_W'(1);
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk) begin
        if (cmd.out_load) begin
            if (count_reg == '0) begin
                minimum_value <= '0;
                maximum_value <= '0;
                spread        <= '0;
                mean_value    <= '0;
                outside_count <= '0;
                status        <= STATUS_EMPTY;
            end
            else begin
                minimum_value <= min_reg;
                maximum_value <= max_reg;
                spread        <= max_reg - min_reg;
                mean_value    <= mean;
                outside_count <= OCNT_W'(outside_reg);
                status        <= ovf_reg ? STATUS_OVERFLOW : STATUS_OK;
            end
            reading_count <= OCNT_W'(count_reg);
        end
    end

endmodule

/* rtl/rsoc_ctrl.sv */
// Controller state machine: sequences loading, division, bounds, scan and
// result hand-off. Depends on rsoc_pkg.
module rsoc_ctrl
    import rsoc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      last_reading,
    output logic      out_valid,
    input  logic      out_ready,
    input  rsoc_sts_t sts,
    output rsoc_cmd_t cmd
);

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       in_xfer;
    logic       out_free;

    assign in_ready  = (state_reg == S_LOAD);
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_LOAD: begin
                cmd.load = in_xfer;
                if (in_xfer && last_reading) begin
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                cmd.div_init = 1'b1;
                state_next   = sts.count_zero ? S_OUT : S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                cmd.scan_issue = 1'b1;
                if (sts.scan_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last compare lands in the outlier count here
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_LOAD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end
        else if (out_ready) begin
            out_valid_next = 1'b0;
        end
        else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_LOAD;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
